// ----- src/tdp_pkg.sv -----
package tdp_pkg;

   // width of the number under test and of the echoed value and divisor fields
   localparam int VALUE_BITS = 31;
   // the running square of the trial divisor needs headroom above the number
   localparam int SQ_BITS    = VALUE_BITS + 2;
   // bit counter of the serial remainder unit
   localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

   // first odd trial divisor and its square
   localparam logic [VALUE_BITS-1:0] FIRST_DIV = VALUE_BITS'(3);
   localparam logic [SQ_BITS-1:0]    FIRST_SQ  = SQ_BITS'(9);
   localparam logic [VALUE_BITS-1:0] EVEN_DIV  = VALUE_BITS'(2);

   // status from the serial remainder unit
   typedef struct packed {
      logic done;   // remainder valid this cycle
      logic zero;   // remainder is zero
   } rem_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

endpackage

// ----- src/tdp_if.sv -----
interface tdp_req_if;
   logic                           valid;
   logic                           ready;
   logic [tdp_pkg::VALUE_BITS-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

interface tdp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tdp_pkg::VALUE_BITS-1:0] tested_value;
   logic                           prime_flag;
   logic [tdp_pkg::VALUE_BITS-1:0] smallest_divisor;

   modport source (output valid, output tested_value, output prime_flag,
                   output smallest_divisor, input ready);
   modport sink   (input valid, input tested_value, input prime_flag,
                   input smallest_divisor, output ready);
endinterface

// ----- src/tdp_rem.sv -----
module tdp_rem (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [tdp_pkg::VALUE_BITS-1:0] dividend,
   input  logic [tdp_pkg::VALUE_BITS-1:0] divisor,
   output tdp_pkg::rem_stat_type          stat
);

   logic [tdp_pkg::VALUE_BITS-1:0] shift_ff, shift_in;
   logic [tdp_pkg::VALUE_BITS:0]   rem_ff, rem_in;
   logic [tdp_pkg::CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                           running_ff, running_in;
   logic                           done_ff, done_in;
   logic [tdp_pkg::VALUE_BITS:0]   rem_shifted;

   // one restoring step: bring in the next dividend bit, subtract if it fits
   always_comb begin
      rem_shifted = {rem_ff[tdp_pkg::VALUE_BITS-1:0], shift_ff[tdp_pkg::VALUE_BITS-1]};
      shift_in    = shift_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      running_in  = running_ff;
      done_in     = 1'b0;
      if (start) begin
         shift_in   = dividend;
         rem_in     = '0;
         cnt_in     = tdp_pkg::CNT_BITS'(tdp_pkg::VALUE_BITS);
         running_in = 1'b1;
      end else if (running_ff) begin
         shift_in = {shift_ff[tdp_pkg::VALUE_BITS-2:0], 1'b0};
         if (rem_shifted >= {1'b0, divisor}) begin
            rem_in = rem_shifted - {1'b0, divisor};
         end else begin
            rem_in = rem_shifted;
         end
         cnt_in = cnt_ff - tdp_pkg::CNT_BITS'(1);
         if (cnt_ff == tdp_pkg::CNT_BITS'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

   assign stat.done = done_ff;
   assign stat.zero = (rem_ff == '0);

endmodule

// ----- src/trial_division_prime_test.sv -----
// Trial-division primality test. Each transfer on req_chan carries one number; one
// result follows on rsp_chan with the number echoed, a prime flag and the smallest
// divisor found (2 for even numbers, 0 when the number is prime or below 2; 0 is
// reported with divisor 2, 1 and 0 are not prime, 2 is prime). Even numbers and
// 0, 1, 2 are decided without a trial. An odd number tries the odd divisors 3, 5,
// 7, ... while the divisor squared does not exceed the number, each trial on the
// bit-serial remainder unit that produces one remainder bit per cycle; a prime n
// is tried against about sqrt(n)/2 divisors. One number is worked on at a time; a
// new one is taken as soon as the previous result has moved to the output
// register, even while that result still waits for rsp_chan.ready.
module trial_division_prime_test (
   input  logic       clock,
   input  logic       reset,
   tdp_req_if.sink    req_chan,
   tdp_rsp_if.source  rsp_chan
);

   tdp_pkg::state_type             state_ff, state_in;
   logic [tdp_pkg::VALUE_BITS-1:0] n_ff, n_in;
   logic [tdp_pkg::VALUE_BITS-1:0] d_ff, d_in;
   logic [tdp_pkg::SQ_BITS-1:0]    sq_ff, sq_in;
   logic                           res_prime_ff, res_prime_in;
   logic [tdp_pkg::VALUE_BITS-1:0] res_div_ff, res_div_in;
   logic                           out_valid_ff, out_valid_in;
   logic [tdp_pkg::VALUE_BITS-1:0] out_value_ff, out_value_in;
   logic                           out_prime_ff, out_prime_in;
   logic [tdp_pkg::VALUE_BITS-1:0] out_div_ff, out_div_in;
   logic                           rem_start;
   tdp_pkg::rem_stat_type          rem_stat;

   // serial remainder of the number by the current trial divisor
   tdp_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (n_ff),
      .divisor  (d_ff),
      .stat     (rem_stat)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      res_prime_in = res_prime_ff;
      res_div_in   = res_div_ff;
      rem_start    = 1'b0;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_value_in = out_value_ff;
      out_prime_in = out_prime_ff;
      out_div_in   = out_div_ff;
      unique case (state_ff)
         tdp_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               n_in  = req_chan.candidate;
               d_in  = tdp_pkg::FIRST_DIV;
               sq_in = tdp_pkg::FIRST_SQ;
               if (req_chan.candidate < tdp_pkg::EVEN_DIV) begin
                  // zero is even, one has no divisor
                  res_prime_in = 1'b0;
                  res_div_in   = (req_chan.candidate == '0) ? tdp_pkg::EVEN_DIV : '0;
                  state_in     = tdp_pkg::ST_DONE;
               end else if (req_chan.candidate == tdp_pkg::EVEN_DIV) begin
                  res_prime_in = 1'b1;
                  res_div_in   = '0;
                  state_in     = tdp_pkg::ST_DONE;
               end else if (!req_chan.candidate[0]) begin
                  res_prime_in = 1'b0;
                  res_div_in   = tdp_pkg::EVEN_DIV;
                  state_in     = tdp_pkg::ST_DONE;
               end else begin
                  state_in = tdp_pkg::ST_CHECK;
               end
            end
         end
         tdp_pkg::ST_CHECK: begin
            // divisor beyond the square root: no factor left to find
            if (sq_ff > {2'b00, n_ff}) begin
               res_prime_in = 1'b1;
               res_div_in   = '0;
               state_in     = tdp_pkg::ST_DONE;
            end else begin
               rem_start = 1'b1;
               state_in  = tdp_pkg::ST_DIVIDE;
            end
         end
         tdp_pkg::ST_DIVIDE: begin
            if (rem_stat.done) begin
               if (rem_stat.zero) begin
                  res_prime_in = 1'b0;
                  res_div_in   = d_ff;
                  state_in     = tdp_pkg::ST_DONE;
               end else begin
                  // (d + 2)^2 = d^2 + 4d + 4
                  d_in     = d_ff + tdp_pkg::VALUE_BITS'(2);
                  sq_in    = sq_ff + {d_ff, 2'b00} + tdp_pkg::SQ_BITS'(4);
                  state_in = tdp_pkg::ST_CHECK;
               end
            end
         end
         tdp_pkg::ST_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in = 1'b1;
               out_value_in = n_ff;
               out_prime_in = res_prime_ff;
               out_div_in   = res_div_ff;
               state_in     = tdp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tdp_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdp_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath and result registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      res_prime_ff <= res_prime_in;
      res_div_ff   <= res_div_in;
      out_value_ff <= out_value_in;
      out_prime_ff <= out_prime_in;
      out_div_ff   <= out_div_in;
   end

   assign req_chan.ready            = (state_ff == tdp_pkg::ST_IDLE);
   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.tested_value     = out_value_ff;
   assign rsp_chan.prime_flag       = out_prime_ff;
   assign rsp_chan.smallest_divisor = out_div_ff;

`ifndef NO_ASSERTIONS
   // a remainder only completes while a trial is in progress
   a_rem_in_divide: assert property (@(posedge clock) disable iff (reset)
      rem_stat.done |-> (state_ff == tdp_pkg::ST_DIVIDE))
      else $error("remainder completed outside a trial");

   // a trial divisor is always odd and at least three
   a_div_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdp_pkg::ST_CHECK) |-> (d_ff[0] && d_ff != tdp_pkg::VALUE_BITS'(1)))
      else $error("trial divisor not an odd number of three or more");

   // an exact division ends the test as composite with that divisor
   a_exact_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdp_pkg::ST_DIVIDE && rem_stat.done && rem_stat.zero) |=>
      (state_ff == tdp_pkg::ST_DONE && !res_prime_ff && res_div_ff == $past(d_ff)))
      else $error("exact division did not end the test");

   // a prime verdict never carries a divisor
   a_prime_no_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdp_pkg::ST_DONE && res_prime_ff) |-> (res_div_ff == '0))
      else $error("prime result with a divisor");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // verdict on one number, laid out as the result channel carries it
   typedef struct packed {
      logic [tdp_pkg::VALUE_BITS-1:0] tested_value;
      logic                           prime_flag;
      logic [tdp_pkg::VALUE_BITS-1:0] smallest_divisor;
   } verdict_type;

   localparam int unsigned HOLD_AFTER   = 30;     // results before the long hold-off
   localparam int unsigned HOLD_CYCLES  = 20000;  // long enough for any small number
   localparam int unsigned DRAIN_CYCLES = 100;
   localparam int unsigned RANDOM_COUNT = 116;
   localparam int unsigned MAX_GAP      = 200;

   logic clock;
   logic reset;

   tdp_req_if req_if ();
   tdp_rsp_if rsp_if ();

   trial_division_prime_test dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // edge values, squares of primes, primes with long searches, near-maximum and alternating-bit patterns
   int unsigned edge_numbers [24] = '{
      0, 1, 2, 3, 4, 5, 7, 9, 15, 25, 49, 121, 7919, 65537, 63001, 1022117,
      1048573, 16752649, 32'h7FFFFFFE, 32'h7FFFFFFD, 32'h40000000, 32'h2AAAAAAA,
      32'h55555555, 2147483643
   };

   logic [tdp_pkg::VALUE_BITS-1:0] pending_numbers [$];
   verdict_type                    expected_verdicts [$];

   int unsigned send_gap        = 0;
   int unsigned recv_gap        = 0;
   int unsigned numbers_sent    = 0;
   int unsigned results_seen    = 0;
   int unsigned primes_seen     = 0;
   int unsigned mismatch_count  = 0;
   int unsigned hold_left       = 0;
   int unsigned cycle_limit     = 0;
   int unsigned accept_trials   = 0;
   bit          hold_started    = 1'b0;
   bit          input_backed_up = 1'b0;

   // clock, period 4 ns
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // primality by odd trial divisors while the divisor squared fits under the number
   function automatic verdict_type judge_number(
      input  logic [tdp_pkg::VALUE_BITS-1:0] number,
      output int unsigned                    trials);
      logic [63:0] n;
      logic [63:0] d;
      verdict_type v;
      n = 64'(number);
      trials = 0;
      v.tested_value     = number;
      v.prime_flag       = 1'b0;
      v.smallest_divisor = '0;
      if (n < 64'(tdp_pkg::EVEN_DIV)) begin
         if (n == 0) v.smallest_divisor = tdp_pkg::EVEN_DIV;
      end else if (n == 64'(tdp_pkg::EVEN_DIV)) begin
         v.prime_flag = 1'b1;
      end else if (!n[0]) begin
         v.smallest_divisor = tdp_pkg::EVEN_DIV;
      end else begin
         v.prime_flag = 1'b1;
         for (d = 64'(tdp_pkg::FIRST_DIV); d * d <= n && v.prime_flag; d += 2) begin
            trials++;
            if (n % d == 0) begin
               v.prime_flag       = 1'b0;
               v.smallest_divisor = tdp_pkg::VALUE_BITS'(d);
            end
         end
      end
      return v;
   endfunction

   // mostly small numbers; large ones are even or carry a small odd factor
   function automatic logic [tdp_pkg::VALUE_BITS-1:0] random_candidate();
      int unsigned roll;
      int unsigned factor;
      int unsigned span;
      int unsigned cofactor;
      roll = $urandom_range(0, 99);
      if (roll < 45) return tdp_pkg::VALUE_BITS'($urandom_range(0, 4095));
      if (roll < 60) return tdp_pkg::VALUE_BITS'($urandom_range(0, 65535));
      if (roll < 80) return tdp_pkg::VALUE_BITS'($urandom) & ~tdp_pkg::VALUE_BITS'(1);
      if (roll < 95) begin
         factor   = 2 * $urandom_range(1, 49) + 1;
         span     = 32'h7FFFFFFF / factor;
         cofactor = $urandom_range(0, span - 1) | 1;
         return tdp_pkg::VALUE_BITS'(factor * cofactor);
      end
      return tdp_pkg::VALUE_BITS'($urandom_range(0, 1048575));
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap(input bit steady);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 20);
      return $urandom_range(40, MAX_GAP);
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch: %s", msg);
   endtask

   // request driver, fed from the pending queue
   always @(posedge clock) begin : number_driver
      int unsigned gap;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap     <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_verdicts.push_back(judge_number(req_if.candidate, accept_trials));
            numbers_sent <= numbers_sent + 1;
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap != 0) begin
               req_if.valid <= 1'b0;
               send_gap     <= send_gap - 1;
            end else if (pending_numbers.size() != 0) begin
               gap = pick_gap(numbers_sent >= 70 && numbers_sent < 100);
               req_if.valid     <= 1'b1;
               req_if.candidate <= pending_numbers.pop_front();
               send_gap         <= gap;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // long hold-off on the result side, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_left       <= 0;
         hold_started    <= 1'b0;
         input_backed_up <= 1'b0;
      end else if (!hold_started && results_seen >= HOLD_AFTER) begin
         hold_left    <= HOLD_CYCLES;
         hold_started <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         if (hold_left < 100 && req_if.valid && !req_if.ready) input_backed_up <= 1'b1;
      end
   end

   // result monitor: check each transfer against the oldest verdict, then pace ready
   always @(posedge clock) begin : result_monitor
      verdict_type want;
      int unsigned gap;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_gap     <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen <= results_seen + 1;
            if (expected_verdicts.size() == 0) begin
               flag_mismatch($sformatf("result for %0d with none outstanding",
                                       rsp_if.tested_value));
            end else begin
               want = expected_verdicts.pop_front();
               if (want.prime_flag) primes_seen++;
               if (rsp_if.tested_value !== want.tested_value)
                  flag_mismatch($sformatf("tested_value %0d, wanted %0d",
                                          rsp_if.tested_value, want.tested_value));
               if (rsp_if.prime_flag !== want.prime_flag)
                  flag_mismatch($sformatf("prime_flag %b for %0d, wanted %b",
                                          rsp_if.prime_flag, want.tested_value,
                                          want.prime_flag));
               if (rsp_if.smallest_divisor !== want.smallest_divisor)
                  flag_mismatch($sformatf("smallest_divisor %0d for %0d, wanted %0d",
                                          rsp_if.smallest_divisor, want.tested_value,
                                          want.smallest_divisor));
            end
         end
         if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
         end else if (recv_gap != 0) begin
            rsp_if.ready <= 1'b0;
            recv_gap     <= recv_gap - 1;
         end else if (rsp_if.valid && rsp_if.ready) begin
            gap = pick_gap(results_seen >= 100 && results_seen < 130);
            rsp_if.ready <= (gap == 0);
            recv_gap     <= (gap == 0) ? 0 : gap - 1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin : watchdog
      int unsigned waited;
      waited = 0;
      @(posedge clock);
      while (waited < cycle_limit) begin
         @(posedge clock);
         waited++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // stimulus, budget and end of run
   initial begin : stimulus
      int unsigned                    trials;
      longint unsigned                budget;
      verdict_type                    unused;
      logic [tdp_pkg::VALUE_BITS-1:0] number;
      req_if.valid     = 1'b0;
      req_if.candidate = '0;
      rsp_if.ready     = 1'b0;
      reset            = 1'b1;

      foreach (edge_numbers[i])
         pending_numbers.push_back(tdp_pkg::VALUE_BITS'(edge_numbers[i]));
      for (int i = 0; i < RANDOM_COUNT; i++) pending_numbers.push_back(random_candidate());

      // slowest correct run: every trial, every gap on both sides, the hold-off
      budget = 0;
      foreach (pending_numbers[i]) begin
         number = pending_numbers[i];
         unused = judge_number(number, trials);
         budget += 4 + 34 * (trials + 1) + 2 * MAX_GAP;
      end
      budget      = 4 * (budget + HOLD_CYCLES + DRAIN_CYCLES + 100);
      cycle_limit = int'(budget);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_numbers.size() != 0 || req_if.valid || expected_verdicts.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d numbers (%0d edge values), %0d of them prime",
               numbers_sent, $size(edge_numbers), primes_seen);
      $display("result side held off %0d cycles, input backed up meanwhile: %0s",
               HOLD_CYCLES, input_backed_up ? "yes" : "no");
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- trial_division_prime_test.f -----
src/tdp_pkg.sv
src/tdp_if.sv
src/tdp_rem.sv
src/trial_division_prime_test.sv
tb/sv/testbench.sv
